/* hdl/kth_largest_next_prime_insert_assert.svh */
// Assertion macros for the kth_largest_next_prime_insert checker.
// Included by the checker file only.
`ifndef KTH_LARGEST_NEXT_PRIME_INSERT_ASSERT_SVH
`define KTH_LARGEST_NEXT_PRIME_INSERT_ASSERT_SVH
// Clocked implication, disabled during reset.
`define KLP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define KLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/klnp_pkg.sv */
// Package for kth_largest_next_prime_insert: command and status codes, widths.
// No dependencies.
`timescale 1ns / 1ps
package klnp_pkg;
  localparam int DEF_LIST_DEPTH = 16;
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NORANK  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADIDX  = 2'd3;
  // handshake between sequencer and prime search unit
  typedef struct packed {
    logic        start;
    logic [31:0] base;
  } prime_req_t;
  typedef struct packed {
    logic        done;
    logic [30:0] prime;
  } prime_rsp_t;
endpackage

/* hdl/klnp_prime.sv */
// Prime search unit: smallest prime above a signed base, odd trial division.
// Uses klnp_pkg. One restoring divide step per cycle.
`timescale 1ns / 1ps
module klnp_prime
  import klnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  prime_req_t req,
  output prime_rsp_t rsp
);
  localparam logic [2:0] P_IDLE = 3'd0, P_CAND = 3'd1, P_DIVS = 3'd2,
                         P_DIV = 3'd3, P_CHK = 3'd4;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] cand_r, cand_nxt;   // candidate, up to 2^31-1
  logic [31:0] div_r, div_nxt;     // trial divisor (odd)
  logic [31:0] rem_r, rem_nxt;     // partial remainder
  logic [31:0] quo_r, quo_nxt;     // shifting dividend bits
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] sq;
  logic [32:0] trial;
  logic [32:0] shl;

  assign sq    = div_r * div_r;
  assign shl   = {rem_r, quo_r[31]};
  assign trial = shl - {1'b0, div_r};

  always_comb begin
    st_nxt = st_r; cand_nxt = cand_r; div_nxt = div_r; rem_nxt = rem_r;
    quo_nxt = quo_r; cnt_nxt = cnt_r; done_nxt = 1'b0;
    unique case (st_r)
      P_IDLE: begin
        if (req.start) begin
          if ($signed(req.base) < 32'sd2) begin
            cand_nxt = 32'd2; done_nxt = 1'b1;
          end else begin
            cand_nxt = req.base + 32'd1; st_nxt = P_CAND;
          end
        end
      end
      P_CAND: begin
        if (cand_r == 32'd2 || cand_r == 32'd3) begin
          done_nxt = 1'b1; st_nxt = P_IDLE;
        end else if (!cand_r[0]) begin
          cand_nxt = cand_r + 32'd1;
        end else begin
          div_nxt = 32'd3; st_nxt = P_DIVS;
        end
      end
      P_DIVS: begin
        if (sq > {32'd0, cand_r}) begin
          done_nxt = 1'b1; st_nxt = P_IDLE;
        end else begin
          rem_nxt = '0; quo_nxt = cand_r; cnt_nxt = 6'd32; st_nxt = P_DIV;
        end
      end
      P_DIV: begin
        rem_nxt = trial[32] ? shl[31:0] : trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) st_nxt = P_CHK;
      end
      P_CHK: begin
        if (rem_r == 32'd0) begin
          cand_nxt = cand_r + 32'd2; st_nxt = P_CAND;
        end else begin
          div_nxt = div_r + 32'd2; st_nxt = P_DIVS;
        end
      end
      default: st_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= P_IDLE; done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; done_r <= done_nxt;
    end
    cand_r <= cand_nxt; div_r <= div_nxt; rem_r <= rem_nxt;
    quo_r <= quo_nxt; cnt_r <= cnt_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.prime = cand_r[30:0];
endmodule

/* hdl/kth_largest_next_prime_insert.sv */
// Top level of kth_largest_next_prime_insert: list store, scan sequencer.
// Uses klnp_pkg and klnp_prime.
// One word at a time. Append and no-op go from decode to the output; a
// read fetches the word first. A query runs k scans of the list, fetching
// and then comparing each element, with a round step after each scan.
// Then comes the prime search unit, whose cost is set by trial division:
// one divide bit per cycle, for each odd divisor up to the square root of
// each candidate. An insert then shifts the tail up one slot at a time,
// reading and then writing each element. The result sits in an output
// register. in_stall is high after accept until that result has been
// taken.
`timescale 1ns / 1ps
module kth_largest_next_prime_insert
  import klnp_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic signed [31:0] in_value_in,
  input  logic [4:0]  in_rank_k,
  input  logic [3:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_kth_value,
  output logic [30:0] out_next_prime,
  output logic [3:0]  out_found_position,
  output logic [4:0]  out_list_length
);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2,
    S_SCANW = 4'd3, S_RND = 4'd4, S_PRIME = 4'd5, S_SHRD = 4'd6,
    S_SHWR = 4'd7, S_INS = 4'd8, S_READ = 4'd9, S_RDW = 4'd10, S_OUT = 4'd11,
    S_HOLD = 4'd12;

  logic [3:0]  st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  cmd_r;
  logic [31:0] val_r;
  logic [4:0]  k_r;
  logic [3:0]  idx_r;
  // scan state
  logic [CW-1:0] i_r, i_nxt;      // element being fetched
  logic [CW-1:0] j_r, j_nxt;      // element whose data is on rd_q
  logic [4:0]  rnd_r, rnd_nxt;
  logic        hb_r, hb_nxt;      // bound valid
  logic signed [31:0] bnd_r, bnd_nxt;
  logic        fnd_r, fnd_nxt;
  logic signed [31:0] best_r, best_nxt;
  logic [CW-1:0] where_r, where_nxt;
  // memory
  logic [31:0] mem [LIST_DEPTH];
  logic [31:0] rd_q;
  logic [AW-1:0] ra, wa;
  logic          we;
  logic [31:0]   wd;
  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [31:0] ok_r, ok_nxt;
  logic [30:0] op_r, op_nxt;
  logic [3:0]  opos_r, opos_nxt;
  prime_req_t  preq;
  prime_rsp_t  prsp;
  logic signed [31:0] e;

  klnp_prime u_prime (.clk(clk), .rst_n(rst_n), .req(preq), .rsp(prsp));

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  assign e = $signed(rd_q);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r; rnd_nxt = rnd_r;
    hb_nxt = hb_r; bnd_nxt = bnd_r; fnd_nxt = fnd_r; best_nxt = best_r;
    where_nxt = where_r; ov_nxt = ov_r; os_nxt = os_r; ok_nxt = ok_r;
    op_nxt = op_r; opos_nxt = opos_r;
    ra = i_r[AW-1:0]; wa = cnt_r[AW-1:0]; we = 1'b0; wd = val_r;
    preq.start = 1'b0; preq.base = bnd_r;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_DEC;
      S_DEC: begin
        os_nxt = ST_OK; ok_nxt = '0; op_nxt = '0; opos_nxt = '0;
        unique case (cmd_r)
          CMD_APPEND: begin
            if (cnt_r >= DEPTH_C) os_nxt = ST_FULL;
            else begin
              we = 1'b1; cnt_nxt = cnt_r + CW'(1);
            end
            st_nxt = S_OUT;
          end
          CMD_QUERY: begin
            if (cnt_r == '0 || cnt_r >= DEPTH_C) begin
              os_nxt = ST_FULL; st_nxt = S_OUT;
            end else if (k_r == 5'd0) begin
              os_nxt = ST_NORANK; st_nxt = S_OUT;
            end else begin
              hb_nxt = 1'b0; rnd_nxt = 5'd0; fnd_nxt = 1'b0;
              i_nxt = '0; st_nxt = S_SCAN;
            end
          end
          CMD_READ: begin
            if ({1'b0, idx_r} >= (CW+1)'(cnt_r) ||
                {1'b0, idx_r} >= (CW+1)'(LIST_DEPTH)) begin
              os_nxt = ST_BADIDX; st_nxt = S_OUT;
            end else st_nxt = S_READ;
          end
          default: st_nxt = S_OUT;
        endcase
      end
      S_SCAN: begin
        // issue read of element i
        ra = i_r[AW-1:0]; j_nxt = i_r; i_nxt = i_r + CW'(1); st_nxt = S_SCANW;
      end
      S_SCANW: begin
        if ((!hb_r || e < bnd_r) && (!fnd_r || e > best_r)) begin
          best_nxt = e; where_nxt = j_r; fnd_nxt = 1'b1;
        end
        if (i_r == cnt_r) st_nxt = S_RND;
        else st_nxt = S_SCAN;
      end
      S_RND: begin
        if (!fnd_r) begin
          os_nxt = ST_NORANK; st_nxt = S_OUT;
        end else begin
          bnd_nxt = best_r; hb_nxt = 1'b1; fnd_nxt = 1'b0;
          rnd_nxt = rnd_r + 5'd1; i_nxt = '0;
          if (rnd_r + 5'd1 == k_r) begin
            ok_nxt = best_r; opos_nxt = 4'(where_r);
            if (best_r > 32'sd2147483646) begin
              os_nxt = ST_NORANK; st_nxt = S_OUT;
            end else begin
              preq.start = 1'b1; preq.base = best_r; st_nxt = S_PRIME;
            end
          end else st_nxt = S_SCAN;
        end
      end
      S_PRIME: begin
        if (prsp.done) begin
          op_nxt = prsp.prime; i_nxt = cnt_r; st_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        // move i-1 to i while i > where+1
        if (i_r == where_r + CW'(1)) st_nxt = S_INS;
        else begin
          ra = AW'(i_r - CW'(1)); st_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; wa = i_r[AW-1:0]; wd = rd_q;
        i_nxt = i_r - CW'(1); st_nxt = S_SHRD;
      end
      S_INS: begin
        we = 1'b1; wa = AW'(where_r + CW'(1)); wd = {1'b0, op_r};
        cnt_nxt = cnt_r + CW'(1); st_nxt = S_OUT;
      end
      S_READ: begin
        ra = AW'(idx_r); st_nxt = S_RDW;
      end
      S_RDW: begin
        ok_nxt = rd_q; st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_HOLD;
      end
      S_HOLD: if (!out_stall) begin
        ov_nxt = 1'b0; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    if (st_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd; val_r <= in_value_in; k_r <= in_rank_k; idx_r <= in_read_index;
    end
    i_r <= i_nxt; j_r <= j_nxt; rnd_r <= rnd_nxt; hb_r <= hb_nxt; bnd_r <= bnd_nxt;
    fnd_r <= fnd_nxt; best_r <= best_nxt; where_r <= where_nxt;
    os_r <= os_nxt; ok_r <= ok_nxt; op_r <= op_nxt; opos_r <= opos_nxt;
  end

  assign in_stall           = (st_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_kth_value      = ok_r;
  assign out_next_prime     = op_r;
  assign out_found_position = opos_r;
  assign out_list_length    = 5'(cnt_r);
endmodule

/* hdl/klnp_checker.sv */
// Port-level checker for kth_largest_next_prime_insert, bound to the top.
// Uses klnp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "kth_largest_next_prime_insert_assert.svh"
module klnp_port_assert
  import klnp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [30:0] out_next_prime,
  input logic [4:0]  out_list_length
);
  `KLP_ASSERT_IMPL(a_busy_when_out, out_valid, in_stall)
  `KLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status))
  `KLP_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall)
  `KLP_ASSERT_IMPL(a_len_range, out_valid, out_list_length <= 5'd16)
  `KLP_ASSERT_IMPL(a_prime_nz, out_valid && out_status != ST_OK, out_next_prime == 31'd0)
endmodule

bind kth_largest_next_prime_insert klnp_port_assert u_klnp_port_assert (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_next_prime(out_next_prime), .out_list_length(out_list_length)
);
